// ===== rtl/m64h_pkg.sv =====
`default_nettype none

package m64h_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned HalfW     = WordW / 2;
  localparam int unsigned InDataW   = 2 * WordW;
  localparam int unsigned OutDataW  = WordW;
  localparam int unsigned NumStages = 12;
  localparam int unsigned SideDepth = 8;
  localparam int unsigned MixlDepth = 2;

  localparam logic [WordW-1:0] MixMul    = 64'hc6a4a7935bd1e995;
  localparam logic [HalfW-1:0] MixMulLo  = MixMul[HalfW-1:0];
  localparam logic [HalfW-1:0] MixMulHi  = MixMul[WordW-1:HalfW];
  localparam int unsigned      MixShift  = 47;
  localparam int unsigned      TailShift = 8;
  localparam logic [WordW-1:0] SeedBase  = 64'h00000000b0f57ee3;
  localparam logic [WordW-1:0] SeedInit  = SeedBase ^ (MixMul << 4);

  typedef logic [NumStages-1:0] stage_vec_t;

  function automatic logic [WordW-1:0] xorshift(input logic [WordW-1:0] v);
    return v ^ (v >> MixShift);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/m64h_mulm.sv =====
`default_nettype none

module m64h_mulm (
  input  wire logic                        clk_i,
  input  wire logic [1:0]                  en_i,
  input  wire logic [m64h_pkg::WordW-1:0]  a_i,
  output logic      [m64h_pkg::WordW-1:0]  p_o
);

  logic [m64h_pkg::WordW-1:0] p0_q, p0_d;
  logic [m64h_pkg::HalfW-1:0] c1_q, c1_d;
  logic [m64h_pkg::HalfW-1:0] c2_q, c2_d;
  logic [m64h_pkg::HalfW-1:0] cross_sum;
  logic [m64h_pkg::WordW-1:0] p_q, p_d;

  always_comb begin
    p0_d = m64h_pkg::WordW'(a_i[m64h_pkg::HalfW-1:0]) * m64h_pkg::WordW'(m64h_pkg::MixMulLo);
    c1_d = a_i[m64h_pkg::HalfW-1:0] * m64h_pkg::MixMulHi;
    c2_d = a_i[m64h_pkg::WordW-1:m64h_pkg::HalfW] * m64h_pkg::MixMulLo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p0_q <= p0_d;
      c1_q <= c1_d;
      c2_q <= c2_d;
    end
  end

  always_comb begin
    cross_sum = c1_q + c2_q;
    p_d       = p0_q + {cross_sum, {m64h_pkg::HalfW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/m64h_ctrl.sv =====
`default_nettype none

module m64h_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output m64h_pkg::stage_vec_t       en_o
);

  m64h_pkg::stage_vec_t valid_q, valid_d;
  m64h_pkg::stage_vec_t en;
  m64h_pkg::stage_vec_t all_ones;
  logic                 in_xfer;
  logic                 out_xfer;

  assign all_ones = '1;

  // advance a stage when the output is ready, or when it or some later stage has room
  always_comb begin
    for (int k = 0; k < m64h_pkg::NumStages; k++) begin
      en[k] = out_ready_i || !(&(valid_q | ~(all_ones << k)));
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < m64h_pkg::NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0] && rst_ni;
  assign out_valid_o = valid_q[m64h_pkg::NumStages-1];
  assign en_o        = en;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

`ifndef SYNTH
  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (~en & ~valid_q) == '0)
    else $error("stalled stage holds no item");

  a_enable_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((en >> 1) & ~en) == '0)
    else $error("later stage advances while earlier stage stalls");

  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> in_ready_o)
    else $error("input stalled with room in pipeline");

  a_count_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> $countones(valid_q) ==
      $countones($past(valid_q)) + int'($past(in_xfer)) - int'($past(out_xfer)))
    else $error("item lost or duplicated in pipeline");
`endif

endmodule

`default_nettype wire

// ===== rtl/murmur64_id_hash.sv =====
// Channel  Dir  Width  Contents
// s_axis   in   128    id_high [63:0], id_low [127:64]
// m_axis   out  64     hash_value [63:0]
//
// Twelve register stages: six chained multiply levels (eight units), two stages each.
// One transfer per cycle while the output is not stalled.
// Reset clears only the stage valid bits; input ready is low while reset is held.
// A stalled output holds the last stage; earlier stages keep filling empty slots.
`default_nettype none

module murmur64_id_hash (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // id_high [63:0], id_low [127:64]
  input  wire logic [m64h_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // hash_value [63:0]
  output logic      [m64h_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  m64h_pkg::stage_vec_t en;

  logic [m64h_pkg::WordW-1:0] id_high, id_low;
  logic [m64h_pkg::WordW-1:0] u1, u2, l1, l2;
  logic [m64h_pkg::WordW-1:0] a1, a2, f1, f2;
  logic [m64h_pkg::WordW-1:0] acc1, acc2, acc3;
  logic [m64h_pkg::InDataW-1:0] side_q [m64h_pkg::SideDepth];
  logic [m64h_pkg::WordW-1:0]   mixl_q [m64h_pkg::MixlDepth];
  logic [m64h_pkg::WordW-1:0]   side_high, side_low;

  assign id_high = s_axis_tdata_i[m64h_pkg::WordW-1:0];
  assign id_low  = s_axis_tdata_i[m64h_pkg::InDataW-1:m64h_pkg::WordW];

  m64h_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .en_o        (en)
  );

  m64h_mulm u_mix_hi1 (.clk_i(clk_i), .en_i(en[1:0]), .a_i(id_high), .p_o(u1));
  m64h_mulm u_mix_lo1 (.clk_i(clk_i), .en_i(en[1:0]), .a_i(id_low),  .p_o(l1));

  m64h_mulm u_mix_hi2 (
    .clk_i(clk_i), .en_i(en[3:2]), .a_i(m64h_pkg::xorshift(u1)), .p_o(u2)
  );
  m64h_mulm u_mix_lo2 (
    .clk_i(clk_i), .en_i(en[3:2]), .a_i(m64h_pkg::xorshift(l1)), .p_o(l2)
  );

  assign acc1 = m64h_pkg::SeedInit ^ u2;
  m64h_mulm u_acc1 (.clk_i(clk_i), .en_i(en[5:4]), .a_i(acc1), .p_o(a1));

  // carry the low-word mix alongside the first accumulator multiply
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      mixl_q[0] <= l2;
    end
    if (en[5]) begin
      mixl_q[1] <= mixl_q[0];
    end
  end

  assign acc2 = a1 ^ mixl_q[m64h_pkg::MixlDepth-1];
  m64h_mulm u_acc2 (.clk_i(clk_i), .en_i(en[7:6]), .a_i(acc2), .p_o(a2));

  // carry the raw identifier to the tail fold
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= s_axis_tdata_i;
    end
  end

  for (genvar k = 1; k < m64h_pkg::SideDepth; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_high = side_q[m64h_pkg::SideDepth-1][m64h_pkg::WordW-1:0];
  assign side_low  = side_q[m64h_pkg::SideDepth-1][m64h_pkg::InDataW-1:m64h_pkg::WordW];
  assign acc3      = a2 ^ (side_low << m64h_pkg::TailShift) ^ side_high;

  m64h_mulm u_fin1 (.clk_i(clk_i), .en_i(en[9:8]), .a_i(acc3), .p_o(f1));
  m64h_mulm u_fin2 (
    .clk_i(clk_i), .en_i(en[11:10]), .a_i(m64h_pkg::xorshift(f1)), .p_o(f2)
  );

  assign m_axis_tdata_o = m64h_pkg::xorshift(f2);

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned PhaseItems    = 450;

  class id_hash_board;
    localparam logic [63:0] Mul   = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] Seed  = 64'h00000000b0f57ee3 ^ (Mul * 64'd16);
    localparam int unsigned Shift = 47;
    localparam int unsigned Tail  = 8;

    logic [63:0] hashes_due[$];
    int unsigned errors;

    function logic [63:0] mix_word(logic [63:0] w);
      logic [63:0] v;
      v = w * Mul;
      v = v ^ (v >> Shift);
      return v * Mul;
    endfunction

    function logic [63:0] hash_of_id(logic [63:0] hi, logic [63:0] lo);
      logic [63:0] acc;
      acc = Seed ^ mix_word(hi);
      acc = acc * Mul;
      acc = acc ^ mix_word(lo);
      acc = acc * Mul;
      acc = acc ^ (lo << Tail) ^ hi;
      acc = acc * Mul;
      acc = acc ^ (acc >> Shift);
      acc = acc * Mul;
      return acc ^ (acc >> Shift);
    endfunction

    function void note_id(logic [63:0] hi, logic [63:0] lo);
      hashes_due.push_back(hash_of_id(hi, lo));
    endfunction

    function void check_hash(logic [63:0] got);
      logic [63:0] want;
      if (hashes_due.size() == 0) begin
        $error("hash_value: unexpected transfer, actual %h", got);
        errors++;
      end else begin
        want = hashes_due.pop_front();
        if (got !== want) begin
          $error("hash_value: expected %h, actual %h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [m64h_pkg::InDataW-1:0]     s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [m64h_pkg::OutDataW-1:0]    m_tdata;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 64;
  int unsigned idle_cycles = 0;

  id_hash_board ids_in_flight = new();

  murmur64_id_hash i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      ids_in_flight.check_hash(m_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(4))
      0:       return 64'h1 << $urandom_range(63);
      1:       return ~(64'h1 << $urandom_range(63));
      2:       return 64'($urandom_range(255));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_id(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lo, hi};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    ids_in_flight.note_id(hi, lo);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_id(64'h0, 64'h0);
    send_id('1, '1);
    send_id(64'h0, '1);
    send_id('1, 64'h0);
    send_id(64'h1, 64'h0);
    send_id(64'h0, 64'h1);
    send_id(64'h8000_0000_0000_0000, 64'h0);
    send_id(64'h0, 64'h8000_0000_0000_0000);
    send_id(64'h0, 64'hff00_0000_0000_0000);
    send_id(64'h0, 64'h00ff_ffff_ffff_ffff);
    send_id(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_id(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_id(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef);
    send_id(64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff);
    send_id(64'h0000_8000_0000_0000, 64'h0000_4000_0000_0000);
    send_id(64'hc6a4_a793_5bd1_e995, 64'hb0f5_7ee3);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        send_id(rand_word(), rand_word());
      end
    end
    s_tvalid <= 1'b0;

    while (ids_in_flight.hashes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (ids_in_flight.errors == 0 && ids_in_flight.hashes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/m64h_pkg.sv
rtl/m64h_mulm.sv
rtl/m64h_ctrl.sv
rtl/murmur64_id_hash.sv
dv/tb_top.sv
